[rtl/core/tlvmff_pkg.sv]
package tlvmff_pkg;

  localparam int DEF_MAX_MESSAGE_BYTES = 4096;
  localparam int DEF_HEADER_BYTES      = 7;

  localparam logic [7:0] TARGET_RESET = 8'h02;
  localparam int         WORD_BYTES   = 4;

  localparam int OFFSET_W = 12;
  localparam int LENGTH_W = 16;
  localparam int VWORD_W  = 8 * WORD_BYTES;
  localparam int OUT_W    = 64;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_SKIP    = 3'd4,
    PH_CAPTURE = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef struct packed {
    logic                too_long;
    logic                word_valid;
    logic [VWORD_W-1:0]  value_word;
    logic [LENGTH_W-1:0] value_length;
    logic [OFFSET_W-1:0] value_offset;
    logic                found;
  } result_t;

endpackage

[rtl/core/tlv_message_field_finder.sv]
// Latency: the result word is shown on the cycle after the last message byte is accepted.
// Throughput: one message byte per cycle while in_tready is high, one parser update per byte.
// The output register holds one result, and a new byte is taken while it is read out.
// Reset (rst_n low, synchronous) clears the parser and output valid and sets the target type to 2.
module tlv_message_field_finder
  import tlvmff_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES,
  parameter int HEADER_BYTES      = DEF_HEADER_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // last_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  // [0] found, [12:1] value_offset, [28:13] value_length, [60:29] value_word,
  // [61] word_valid, [62] too_long, [63] zero
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);

  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int END_W = ((POS_W > LENGTH_W) ? POS_W : LENGTH_W) + 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);

  logic [7:0]          target_r;
  logic [POS_W-1:0]    pos_r, pos_stp, pos_nxt;
  phase_t              phase_r, phase_stp, phase_nxt, phase_eff;
  logic [7:0]          rtype_r, rtype_stp, rtype_nxt;
  logic [LENGTH_W-1:0] left_r, left_stp, left_nxt;
  logic                mseen_r, mseen_stp, mseen_nxt;
  logic [POS_W-1:0]    moff_r, moff_stp, moff_nxt;
  logic [LENGTH_W-1:0] mlen_r, mlen_stp, mlen_nxt;
  logic [END_W-1:0]    mend_r, mend_stp, mend_nxt;
  logic [VWORD_W-1:0]  word_r, word_stp, word_nxt;
  logic                ovf_r, ovf_stp, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             res_r, res_nxt;

  logic                in_fire;
  logic                take;
  logic                hdr_pending;
  logic [LENGTH_W-1:0] len_full;
  logic [1:0]          cap_idx;
  logic [2:0]          cap_idx_p1;
  logic                cap_end;
  logic                found;

  assign in_fire     = in_tvalid && in_tready;
  assign in_tready   = !out_valid_r || out_tready;
  assign cfg_ready   = 1'b1;
  assign take        = (pos_r != POS_MAX);
  assign hdr_pending = (32'(pos_r) < HEADER_BYTES);
  assign phase_eff   = (phase_r == PH_HEADER && !hdr_pending) ? PH_TYPE : phase_r;
  assign len_full    = {in_tdata, left_r[7:0]};
  assign cap_idx     = 2'(pos_r - moff_r);
  assign cap_idx_p1  = {1'b0, cap_idx} + 3'd1;
  assign cap_end     = (cap_idx == 2'd3) || (mlen_r <= LENGTH_W'(cap_idx_p1));

  always_comb begin
    phase_stp = phase_r;
    if (take) begin
      case (phase_eff)
        PH_HEADER:  phase_stp = PH_HEADER;
        PH_TYPE:    phase_stp = PH_LEN_LO;
        PH_LEN_LO:  phase_stp = PH_LEN_HI;
        PH_LEN_HI: begin
          if (rtype_r == target_r) begin
            phase_stp = (len_full == '0) ? PH_DONE : PH_CAPTURE;
          end else begin
            phase_stp = (len_full == '0) ? PH_TYPE : PH_SKIP;
          end
        end
        PH_SKIP:    phase_stp = (left_r == LENGTH_W'(1)) ? PH_TYPE : PH_SKIP;
        PH_CAPTURE: phase_stp = cap_end ? PH_DONE : PH_CAPTURE;
        default:    phase_stp = phase_eff;
      endcase
    end
    phase_nxt = phase_r;
    if (in_fire) begin
      phase_nxt = in_tlast ? PH_HEADER : phase_stp;
    end
  end

  always_comb begin
    pos_stp   = pos_r;
    rtype_stp = rtype_r;
    left_stp  = left_r;
    mseen_stp = mseen_r;
    moff_stp  = moff_r;
    mlen_stp  = mlen_r;
    mend_stp  = mend_r;
    word_stp  = word_r;
    ovf_stp   = ovf_r;
    if (!take) begin
      ovf_stp = 1'b1;
    end else begin
      pos_stp = pos_r + POS_W'(1);
      case (phase_eff)
        PH_TYPE:   rtype_stp = in_tdata;
        PH_LEN_LO: left_stp  = LENGTH_W'(in_tdata);
        PH_LEN_HI: begin
          left_stp = len_full;
          if (rtype_r == target_r) begin
            mseen_stp = 1'b1;
            moff_stp  = pos_r + POS_W'(1);
            mlen_stp  = len_full;
            mend_stp  = END_W'(pos_r) + END_W'(1) + END_W'(len_full);
            word_stp  = '0;
          end
        end
        PH_SKIP:    left_stp = left_r - LENGTH_W'(1);
        PH_CAPTURE: word_stp = word_r | (VWORD_W'(in_tdata) << {cap_idx, 3'b000});
        default:    ;
      endcase
    end

    found = mseen_stp && (mend_stp <= END_W'(pos_stp));

    res_nxt.found        = found;
    res_nxt.value_offset = found ? OFFSET_W'(moff_stp) : '0;
    res_nxt.value_length = found ? mlen_stp : '0;
    res_nxt.value_word   = found ? word_stp : '0;
    res_nxt.word_valid   = found && (mlen_stp >= LENGTH_W'(WORD_BYTES));
    res_nxt.too_long     = ovf_stp;

    pos_nxt   = pos_r;
    rtype_nxt = rtype_r;
    left_nxt  = left_r;
    mseen_nxt = mseen_r;
    moff_nxt  = moff_r;
    mlen_nxt  = mlen_r;
    mend_nxt  = mend_r;
    word_nxt  = word_r;
    ovf_nxt   = ovf_r;
    if (in_fire) begin
      if (in_tlast) begin
        pos_nxt   = '0;
        rtype_nxt = '0;
        left_nxt  = '0;
        mseen_nxt = 1'b0;
        moff_nxt  = '0;
        mlen_nxt  = '0;
        mend_nxt  = '0;
        word_nxt  = '0;
        ovf_nxt   = 1'b0;
      end else begin
        pos_nxt   = pos_stp;
        rtype_nxt = rtype_stp;
        left_nxt  = left_stp;
        mseen_nxt = mseen_stp;
        moff_nxt  = moff_stp;
        mlen_nxt  = mlen_stp;
        mend_nxt  = mend_stp;
        word_nxt  = word_stp;
        ovf_nxt   = ovf_stp;
      end
    end

    out_valid_nxt = out_valid_r;
    if (in_fire && in_tlast) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_tvalid = out_valid_r;
    out_tdata  = OUT_W'(res_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RESET;
      pos_r       <= '0;
      phase_r     <= PH_HEADER;
      rtype_r     <= '0;
      left_r      <= '0;
      mseen_r     <= 1'b0;
      moff_r      <= '0;
      mlen_r      <= '0;
      mend_r      <= '0;
      word_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_data;
      end
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      rtype_r     <= rtype_nxt;
      left_r      <= left_nxt;
      mseen_r     <= mseen_nxt;
      moff_r      <= moff_nxt;
      mlen_r      <= mlen_nxt;
      mend_r      <= mend_nxt;
      word_r      <= word_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/core/tlvmff_checker.sv]
module tlvmff_checker
  import tlvmff_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tlast,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  result_t res;
  assign res = out_tdata[$bits(result_t)-1:0];

  // A held result word must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // A new result appears only after the last byte of a message was accepted.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("result word without a last byte");

  a_wv_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.word_valid |-> res.found)
    else $error("word_valid without found");

  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.found |->
      res.value_offset == '0 && res.value_length == '0 && res.value_word == '0)
    else $error("fields not zero without a match");

  // A value shorter than four bytes never fills the top byte of the word.
  a_short_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.found && !res.word_valid |-> res.value_word[31:24] == 8'h00)
    else $error("short value filled the top byte");

endmodule

bind tlv_message_field_finder tlvmff_checker u_tlvmff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
